>>> sv/mwe_pkg.sv
// Shared constants and store interface types for the serial EEPROM block.
package mwe_pkg;

   // Store geometry
   localparam int WORDS  = 256;
   localparam int ADDR_W = $clog2(WORDS);
   localparam int WORD_W = 16;

   // Bus decode
   localparam logic [15:0] PIN_ADDR  = 16'hA080;
   localparam logic [15:0] READ_MASK = 16'hA0F0;

   // Pin byte bit positions
   localparam int PIN_CS  = 7;
   localparam int PIN_SK  = 6;
   localparam int PIN_DIN = 1;

   // Erased word value
   localparam logic [WORD_W-1:0] ERASED = '1;

   // Bus operation codes
   localparam logic OP_PIN_WRITE = 1'b0;
   localparam logic OP_PIN_READ  = 1'b1;

   // Serial command codes
   localparam logic [1:0] CMD_EXT   = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_ERASE = 2'd3;

   // Extended command groups (address bits 7..6)
   localparam logic [1:0] EXT_DISABLE   = 2'd0;
   localparam logic [1:0] EXT_WRITE_ALL = 2'd1;
   localparam logic [1:0] EXT_ERASE_ALL = 2'd2;
   localparam logic [1:0] EXT_ENABLE    = 2'd3;

   // Requests from the protocol engine to the word store
   typedef struct packed {
      logic              read;
      logic              commit;
      logic              fill;
      logic [WORD_W-1:0] fill_value;
      logic [WORD_W-1:0] wdata;
      logic [ADDR_W-1:0] addr;
   } store_req_type;

   // Status from the word store back to the protocol engine
   typedef struct packed {
      logic              busy;
      logic              rd_valid;
      logic [WORD_W-1:0] rd_data;
   } store_stat_type;

endpackage

>>> sv/mwe_store.sv
// Word store with single write port, registered read and a fill sweep engine.
module mwe_store (
   input  logic                   clock,
   input  logic                   reset,
   input  mwe_pkg::store_req_type req,
   output mwe_pkg::store_stat_type stat
);
   import mwe_pkg::*;

   logic [WORD_W-1:0] mem [WORDS];

   logic              sweep_ff, sweep_in;
   logic [ADDR_W-1:0] sweep_addr_ff, sweep_addr_in;
   logic [WORD_W-1:0] fill_ff, fill_in;
   logic              rd_pend_ff;
   logic [WORD_W-1:0] rdata_ff;

   // Advance the sweep one word per cycle; start a new one on request
   always_comb begin
      sweep_in      = sweep_ff;
      sweep_addr_in = sweep_addr_ff;
      fill_in       = fill_ff;
      if (sweep_ff) begin
         sweep_addr_in = sweep_addr_ff + 1'b1;
         if (sweep_addr_ff == ADDR_W'(WORDS - 1)) begin
            sweep_in = 1'b0;
         end
      end else if (req.fill) begin
         sweep_in      = 1'b1;
         sweep_addr_in = '0;
         fill_in       = req.fill_value;
      end
   end

   // Hold sweep control; reset starts an erase pass over the whole store
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
         fill_ff       <= ERASED;
         rd_pend_ff    <= 1'b0;
      end else begin
         sweep_ff      <= sweep_in;
         sweep_addr_ff <= sweep_addr_in;
         fill_ff       <= fill_in;
         rd_pend_ff    <= req.read;
      end
   end

   // Write the store: sweep first, else a committed word
   always_ff @(posedge clock) begin
      if (sweep_ff) begin
         mem[sweep_addr_ff] <= fill_ff;
      end else if (req.commit) begin
         mem[req.addr] <= req.wdata;
      end
   end

   // Read the store into a register
   always_ff @(posedge clock) begin
      if (req.read) begin
         rdata_ff <= mem[req.addr];
      end
   end

   assign stat.busy     = sweep_ff | rd_pend_ff;
   assign stat.rd_valid = rd_pend_ff;
   assign stat.rd_data  = rdata_ff;

endmodule

>>> sv/mwe_ctrl.sv
// Serial protocol engine: pin edge detect, bit shifter and command decode.
module mwe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              pin_byte,
   input  mwe_pkg::store_stat_type stat,
   output mwe_pkg::store_req_type  req,
   output logic                    data_out
);
   import mwe_pkg::*;

   typedef enum logic [2:0] {
      PH_NONE = 3'd0,
      PH_CMD  = 3'd1,
      PH_ADDR = 3'd2,
      PH_DATA = 3'd3,
      PH_OUT  = 3'd4,
      PH_PEND = 3'd5
   } phase_type;

   logic              sel_prev_ff, sel_prev_in;
   logic              clk_prev_ff, clk_prev_in;
   logic              idle_ff, idle_in;
   logic              wen_ff, wen_in;
   phase_type         phase_ff, phase_in;
   logic [4:0]        count_ff, count_in;
   logic [1:0]        cmd_ff, cmd_in;
   logic [ADDR_W-1:0] waddr_ff, waddr_in;
   logic [WORD_W-1:0] shift_ff, shift_in;
   logic              dout_ff, dout_in;

   logic              cs, sk, din;
   logic [WORD_W-1:0] shifted;
   logic [4:0]        cnt;

   assign cs  = pin_byte[PIN_CS];
   assign sk  = pin_byte[PIN_SK];
   assign din = pin_byte[PIN_DIN];

   // Apply one pin transaction: select rise, clock rise, clock fall
   always_comb begin
      sel_prev_in = sel_prev_ff;
      clk_prev_in = clk_prev_ff;
      idle_in     = idle_ff;
      wen_in      = wen_ff;
      phase_in    = phase_ff;
      count_in    = count_ff;
      cmd_in      = cmd_ff;
      waddr_in    = waddr_ff;
      shift_in    = shift_ff;
      dout_in     = dout_ff;
      shifted     = '0;
      cnt         = '0;

      req.read       = 1'b0;
      req.commit     = 1'b0;
      req.fill       = 1'b0;
      req.fill_value = ERASED;
      req.wdata      = shift_ff;
      req.addr       = waddr_ff;

      if (step) begin
         // Select rise: commit a pending word or wait for a start bit
         if (!sel_prev_ff && cs) begin
            if (phase_ff == PH_PEND) begin
               req.commit = wen_ff;
               dout_in    = 1'b1;
            end else begin
               idle_in = 1'b1;
            end
            phase_in = PH_NONE;
         end

         // Clock rise: gather one bit
         if (!clk_prev_ff && sk) begin
            shifted = {shift_in[WORD_W-2:0], din};
            cnt     = count_in + 1'b1;
            if (idle_in) begin
               if (din) begin
                  idle_in  = 1'b0;
                  count_in = '0;
                  phase_in = PH_CMD;
               end
            end else begin
               unique case (phase_in)
                  PH_CMD: begin
                     shift_in = shifted;
                     count_in = cnt;
                     if (cnt == 5'd2) begin
                        phase_in = PH_ADDR;
                        count_in = '0;
                        cmd_in   = shifted[1:0];
                     end
                  end
                  PH_ADDR: begin
                     shift_in = shifted;
                     count_in = cnt;
                     if (cnt == 5'd8) begin
                        phase_in = PH_DATA;
                        count_in = '0;
                        waddr_in = shifted[ADDR_W-1:0];
                        if (cmd_ff == CMD_EXT) begin
                           if (shifted[7:6] == EXT_DISABLE) begin
                              wen_in   = 1'b0;
                              phase_in = PH_NONE;
                           end else if (shifted[7:6] == EXT_ENABLE) begin
                              wen_in   = 1'b1;
                              phase_in = PH_NONE;
                           end
                        end
                     end
                  end
                  PH_DATA: begin
                     shift_in = shifted;
                     count_in = cnt;
                     unique case (cmd_ff)
                        CMD_EXT: begin
                           if (cnt == 5'd16) begin
                              count_in = '0;
                              unique case (waddr_ff[7:6])
                                 EXT_DISABLE: begin
                                    wen_in   = 1'b0;
                                    phase_in = PH_NONE;
                                 end
                                 EXT_WRITE_ALL: begin
                                    req.fill       = wen_ff;
                                    req.fill_value = shifted;
                                    phase_in       = PH_PEND;
                                 end
                                 EXT_ERASE_ALL: begin
                                    req.fill       = wen_ff;
                                    req.fill_value = ERASED;
                                    phase_in       = PH_PEND;
                                 end
                                 default: begin
                                    wen_in   = 1'b1;
                                    phase_in = PH_NONE;
                                 end
                              endcase
                           end
                        end
                        CMD_WRITE: begin
                           if (cnt == 5'd16) begin
                              count_in = '0;
                              phase_in = PH_PEND;
                              dout_in  = 1'b0;
                           end
                        end
                        CMD_READ: begin
                           if (cnt == 5'd1) begin
                              count_in = '0;
                              phase_in = PH_OUT;
                              req.read = 1'b1;
                           end
                        end
                        default: begin
                           if (cnt == 5'd16) begin
                              count_in = '0;
                              phase_in = PH_PEND;
                              dout_in  = 1'b0;
                              shift_in = ERASED;
                           end
                        end
                     endcase
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Clock fall while reading out: drive the next bit
         if (clk_prev_ff && !sk && phase_in == PH_OUT) begin
            dout_in  = shift_in[WORD_W-1];
            shift_in = {shift_in[WORD_W-2:0], 1'b0};
            count_in = count_in + 1'b1;
            if (count_in == 5'd16) begin
               count_in = '0;
               phase_in = PH_NONE;
            end
         end

         sel_prev_in = cs;
         clk_prev_in = sk;
      end else if (stat.rd_valid) begin
         // Load the word fetched for a read
         shift_in = stat.rd_data;
      end
   end

   // Hold protocol state
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_prev_ff <= 1'b0;
         clk_prev_ff <= 1'b0;
         idle_ff     <= 1'b0;
         wen_ff      <= 1'b0;
         phase_ff    <= PH_NONE;
         count_ff    <= '0;
         cmd_ff      <= '0;
         waddr_ff    <= '0;
         shift_ff    <= '0;
         dout_ff     <= 1'b0;
      end else begin
         sel_prev_ff <= sel_prev_in;
         clk_prev_ff <= clk_prev_in;
         idle_ff     <= idle_in;
         wen_ff      <= wen_in;
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         cmd_ff      <= cmd_in;
         waddr_ff    <= waddr_in;
         shift_ff    <= shift_in;
         dout_ff     <= dout_in;
      end
   end

   assign data_out = dout_ff;

endmodule

>>> sv/microwire_eeprom_16bit_unit.sv
// Top level of the bit-banged serial EEPROM: bus decode, handshake and result register.
//
// Serial EEPROM of 256 sixteen-bit words driven through one pin register at bus
// address 0xA080 (chip select bit 7, serial clock bit 6, data in bit 1). Pin reads
// (address matching 0xA080 under mask 0xA0F0) return the data-out/ready bit, one
// result per read; pin writes return nothing. The transaction that ends a word read
// is followed by a stall while the store's registered read port fetches the word.
// With writes enabled, write-all and erase-all walk the store one word per cycle
// through its single write port, so the input stalls after the transaction that
// starts them until the sweep ends. After reset the same sweep erases the whole
// store to 0xFFFF, and no transaction is taken until it ends. A read result waits
// in an output register; pin writes keep flowing while it is stalled.
module microwire_eeprom_16bit_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [15:0] req_bus_address,
   input  logic [7:0]  req_pin_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_read_value
);
   import mwe_pkg::*;

   store_req_type  store_req;
   store_stat_type store_stat;

   logic req_accept;
   logic pin_step;
   logic data_out;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_value_ff, rsp_value_in;

   // Stall while the store is busy, or a read finds the result register full and stalled
   assign req_stall  = store_stat.busy |
                       ((req_operation == OP_PIN_READ) & rsp_valid_ff & rsp_stall);
   assign req_accept = req_valid & ~req_stall;
   assign pin_step   = req_accept & (req_operation == OP_PIN_WRITE) &
                       (req_bus_address == PIN_ADDR);

   mwe_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .step     (pin_step),
      .pin_byte (req_pin_byte),
      .stat     (store_stat),
      .req      (store_req),
      .data_out (data_out)
   );

   mwe_store u_store (
      .clock (clock),
      .reset (reset),
      .req   (store_req),
      .stat  (store_stat)
   );

   // Load a read result; drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept && req_operation == OP_PIN_READ) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = ((req_bus_address & READ_MASK) == PIN_ADDR) & data_out;
      end
   end

   // Hold the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

>>> dv/mwe_read_checker.sv
`timescale 1ns / 1ps
// Read-result checker for the serial EEPROM unit: tracks pin traffic and compares reads.
module mwe_read_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_operation,
   input  logic [15:0] req_bus_address,
   input  logic [7:0]  req_pin_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_read_value,
   output int          error_count,
   output int          outstanding,
   output int          checked_count
);
   import mwe_pkg::*;

   typedef enum logic [2:0] {
      STAGE_NONE, STAGE_CMD, STAGE_ADDR, STAGE_DATA, STAGE_SHIFT_OUT, STAGE_COMMIT
   } stage_type;

   // Shadow copy of the serial engine and its word store
   logic              cs_last, sk_last, wait_start, writes_on, dout;
   stage_type         stage;
   logic [4:0]        nbits;
   logic [1:0]        cmd;
   logic [ADDR_W-1:0] waddr;
   logic [WORD_W-1:0] shreg;
   logic [WORD_W-1:0] mem [WORDS];
   logic              pending_bits [$];
   int                errors = 0;
   int                checked = 0;

   task automatic fill_mem(input logic [WORD_W-1:0] value);
      for (int i = 0; i < WORDS; i++) mem[i] = value;
   endtask

   task automatic clear_engine();
      cs_last = 1'b0;
      sk_last = 1'b0;
      wait_start = 1'b0;
      writes_on = 1'b0;
      stage = STAGE_NONE;
      nbits = '0;
      cmd = '0;
      waddr = '0;
      shreg = '0;
      dout = 1'b0;
      fill_mem(ERASED);
   endtask

   task automatic shift_bit(input logic din);
      shreg = {shreg[WORD_W-2:0], din};
      nbits = nbits + 5'd1;
   endtask

   // Advance the engine on a rising serial clock
   task automatic serial_rise(input logic din);
      if (wait_start) begin
         if (din) begin
            wait_start = 1'b0;
            nbits = '0;
            stage = STAGE_CMD;
         end
         return;
      end
      case (stage)
         STAGE_CMD: begin
            shift_bit(din);
            if (nbits == 5'd2) begin
               stage = STAGE_ADDR;
               nbits = '0;
               cmd = shreg[1:0];
            end
         end
         STAGE_ADDR: begin
            shift_bit(din);
            if (nbits == 5'd8) begin
               stage = STAGE_DATA;
               nbits = '0;
               waddr = shreg[7:0];
               // enable and disable take effect right after the address
               if (cmd == CMD_EXT && waddr[7:6] == EXT_DISABLE) begin
                  writes_on = 1'b0;
                  stage = STAGE_NONE;
               end else if (cmd == CMD_EXT && waddr[7:6] == EXT_ENABLE) begin
                  writes_on = 1'b1;
                  stage = STAGE_NONE;
               end
            end
         end
         STAGE_DATA: begin
            shift_bit(din);
            case (cmd)
               CMD_EXT: begin
                  if (nbits == 5'd16) begin
                     case (waddr[7:6])
                        EXT_DISABLE: begin
                           writes_on = 1'b0;
                           stage = STAGE_NONE;
                        end
                        EXT_WRITE_ALL: begin
                           if (writes_on) fill_mem(shreg);
                           stage = STAGE_COMMIT;
                        end
                        EXT_ERASE_ALL: begin
                           if (writes_on) fill_mem(ERASED);
                           stage = STAGE_COMMIT;
                        end
                        default: begin
                           writes_on = 1'b1;
                           stage = STAGE_NONE;
                        end
                     endcase
                     nbits = '0;
                  end
               end
               CMD_WRITE: begin
                  if (nbits == 5'd16) begin
                     nbits = '0;
                     stage = STAGE_COMMIT;
                     dout = 1'b0;
                  end
               end
               CMD_READ: begin
                  // one dummy bit, then load the word
                  if (nbits == 5'd1) begin
                     stage = STAGE_SHIFT_OUT;
                     nbits = '0;
                     shreg = mem[waddr];
                  end
               end
               default: begin
                  if (nbits == 5'd16) begin
                     nbits = '0;
                     stage = STAGE_COMMIT;
                     dout = 1'b0;
                     shreg = ERASED;
                  end
               end
            endcase
         end
         default: ;
      endcase
   endtask

   // Apply one accepted transaction; queue the bit a read must return
   task automatic apply_transaction(input logic op, input logic [15:0] addr,
                                    input logic [7:0] pins);
      logic cs, sk, din;
      if (op == OP_PIN_READ) begin
         pending_bits.push_back(((addr & READ_MASK) == PIN_ADDR) ? dout : 1'b0);
         return;
      end
      if (addr != PIN_ADDR) return;
      cs = pins[PIN_CS];
      sk = pins[PIN_SK];
      din = pins[PIN_DIN];
      // chip select rise: commit a pending store or wait for a start bit
      if (!cs_last && cs) begin
         if (stage == STAGE_COMMIT) begin
            if (writes_on) mem[waddr] = shreg;
            stage = STAGE_NONE;
            dout = 1'b1;
         end else begin
            wait_start = 1'b1;
            stage = STAGE_NONE;
         end
      end
      if (!sk_last && sk) serial_rise(din);
      // falling clock shifts the read word out, MSB first
      if (sk_last && !sk && stage == STAGE_SHIFT_OUT) begin
         dout = shreg[WORD_W-1];
         shreg = {shreg[WORD_W-2:0], 1'b0};
         nbits = nbits + 5'd1;
         if (nbits == 5'd16) begin
            nbits = '0;
            stage = STAGE_NONE;
         end
      end
      cs_last = cs;
      sk_last = sk;
   endtask

   // Compare results first, then fold in the new transaction
   always @(posedge clock) begin : watch
      logic want;
      if (reset) begin
         clear_engine();
         pending_bits.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_bits.size() == 0) begin
               $display("%0t: read result with nothing pending, expected none, got %0b",
                        $time, rsp_read_value);
               errors++;
            end else begin
               want = pending_bits.pop_front();
               checked++;
               if (rsp_read_value !== want) begin
                  $display("%0t: read_value mismatch, expected %0b, got %0b",
                           $time, want, rsp_read_value);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall)
            apply_transaction(req_operation, req_bus_address, req_pin_byte);
      end
      error_count <= errors;
      checked_count <= checked;
      outstanding <= pending_bits.size();
   end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the serial EEPROM unit: stimulus, flow control and verdict.
module tb;
   import mwe_pkg::*;

   localparam int ITEM_TARGET = 500;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 300;
   localparam int CYCLE_LIMIT = 200000;
   // Word addresses that reads and writes favor, extremes among them
   localparam logic [63:0] HOT_WORDS = 64'h0001_3F40_7F80_FEFF;

   typedef enum int {
      JOB_ENABLE, JOB_DISABLE, JOB_WRITE_ALL, JOB_ERASE_ALL,
      JOB_WRITE, JOB_READ, JOB_ERASE, JOB_NOISE
   } job_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_operation = 1'b0;
   logic [15:0] req_bus_address = '0;
   logic [7:0]  req_pin_byte = '0;
   logic        rsp_stall = 1'b0;
   logic        req_stall, rsp_valid, rsp_read_value;
   int          error_count, outstanding, checked_count;
   int          cycle_count = 0;
   int          items_sent = 0;
   int          burst_left = 0;
   bit          hold_now = 1'b0;
   bit          hold_done = 1'b0;
   int          job_count [8];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   microwire_eeprom_16bit_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_bus_address (req_bus_address),
      .req_pin_byte    (req_pin_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_value  (rsp_read_value)
   );

   mwe_read_checker read_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_bus_address (req_bus_address),
      .req_pin_byte    (req_pin_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_value  (rsp_read_value),
      .error_count     (error_count),
      .outstanding     (outstanding),
      .checked_count   (checked_count)
   );

   // Watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb: timeout after %0d cycles", cycle_count);
      $display("tb: done, errors");
      $finish;
   end

   // Offer one transaction in bursts with random gaps; hold until taken
   task automatic put_item(input logic op, input logic [15:0] addr, input logic [7:0] pins);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      burst_left--;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_bus_address <= addr;
      req_pin_byte <= pins;
      do @(posedge clock); while (req_stall);
      if (op == OP_PIN_READ || addr == PIN_ADDR) items_sent++;
   endtask

   // Pin write with random filler in the unused bits
   task automatic pin(input logic cs, input logic sk, input logic din);
      logic [7:0] b;
      b = 8'($urandom);
      b[PIN_CS] = cs;
      b[PIN_SK] = sk;
      b[PIN_DIN] = din;
      put_item(OP_PIN_WRITE, PIN_ADDR, b);
   endtask

   // Read the data-out bit, mostly through a decoded alias
   task automatic poll();
      logic [15:0] a;
      a = 16'($urandom);
      if ($urandom_range(0, 7) != 0) a = PIN_ADDR | (a & ~READ_MASK);
      put_item(OP_PIN_READ, a, 8'($urandom));
   endtask

   function automatic logic [7:0] pick_word();
      logic [2:0] k;
      k = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 9) < 7) return HOT_WORDS[8*k +: 8];
      return 8'($urandom);
   endfunction

   // One serial command: select, start, opcode, address, data, stray clocks
   task automatic run_command(input logic [1:0] code, input logic [7:0] waddr,
                              input logic [15:0] data, input bit cut_short);
      logic [1:0] steps [$];
      int         keep;
      bit         read_cmd, long_cmd;
      read_cmd = (code == CMD_READ);
      long_cmd = (code != CMD_EXT) || (waddr[7:6] == EXT_WRITE_ALL) ||
                 (waddr[7:6] == EXT_ERASE_ALL);
      pin(1'b0, 1'b0, 1'($urandom));
      if ($urandom_range(0, 3) == 0) begin
         // select rise and start bit in the same transaction
         pin(1'b1, 1'b1, 1'b1);
         pin(1'b1, 1'b0, 1'($urandom));
      end else begin
         pin(1'b1, 1'b0, 1'b0);
         repeat ($urandom_range(0, 2)) steps.push_back(2'b00);
         steps.push_back(2'b01);
      end
      poll();
      steps.push_back({$urandom_range(0, 3) == 0, code[1]});
      steps.push_back({$urandom_range(0, 3) == 0, code[0]});
      for (int i = 7; i >= 0; i--) steps.push_back({$urandom_range(0, 3) == 0, waddr[i]});
      if (read_cmd) begin
         for (int i = 0; i < 16; i++) steps.push_back({1'b1, 1'($urandom)});
      end else if (long_cmd) begin
         for (int i = 15; i >= 0; i--) steps.push_back({$urandom_range(0, 3) == 0, data[i]});
      end
      repeat ($urandom_range(0, 2)) steps.push_back({1'b1, 1'($urandom)});
      keep = cut_short ? $urandom_range(0, steps.size()) : steps.size();
      for (int i = 0; i < keep; i++) begin
         pin(1'b1, 1'b1, steps[i][0]);
         pin(1'b1, 1'b0, steps[i][0]);
         if (steps[i][1]) poll();
      end
   endtask

   // Stray traffic: foreign addresses, raw pin bytes, undecoded reads
   task automatic make_noise();
      logic [15:0] a;
      repeat ($urandom_range(1, 4)) begin
         a = 16'($urandom);
         case ($urandom_range(0, 3))
            0: begin
               if (a == PIN_ADDR) a[0] = ~a[0];
               put_item(OP_PIN_WRITE, a, 8'($urandom));
            end
            1: put_item(OP_PIN_WRITE, PIN_ADDR, 8'($urandom));
            2: put_item(OP_PIN_READ, a, 8'($urandom));
            default: poll();
         endcase
      end
   endtask

   task automatic run_job(input job_type job, input bit cut_short);
      case (job)
         JOB_ENABLE:    run_command(CMD_EXT, {EXT_ENABLE, 6'($urandom)}, 16'($urandom),
                                    cut_short);
         JOB_DISABLE:   run_command(CMD_EXT, {EXT_DISABLE, 6'($urandom)}, 16'($urandom),
                                    cut_short);
         JOB_WRITE_ALL: run_command(CMD_EXT, {EXT_WRITE_ALL, 6'($urandom)}, 16'($urandom),
                                    cut_short);
         JOB_ERASE_ALL: run_command(CMD_EXT, {EXT_ERASE_ALL, 6'($urandom)}, 16'($urandom),
                                    cut_short);
         JOB_WRITE:     run_command(CMD_WRITE, pick_word(), 16'($urandom), cut_short);
         JOB_READ:      run_command(CMD_READ, pick_word(), 16'($urandom), cut_short);
         JOB_ERASE:     run_command(CMD_ERASE, pick_word(), 16'($urandom), cut_short);
         default:       make_noise();
      endcase
   endtask

   // Fixed opening order so every command appears early, then weighted random
   function automatic job_type choose_job(input int idx);
      int r;
      case (idx)
         0: return JOB_WRITE;
         1: return JOB_ENABLE;
         2: return JOB_WRITE;
         3: return JOB_READ;
         4: return JOB_ERASE;
         5: return JOB_READ;
         6: return JOB_WRITE_ALL;
         7: return JOB_READ;
         8: return JOB_ERASE_ALL;
         9: return JOB_READ;
         10: return JOB_DISABLE;
         11: return JOB_WRITE;
         12: return JOB_READ;
         default: ;
      endcase
      r = $urandom_range(0, 99);
      if (r < 8) return JOB_ENABLE;
      if (r < 12) return JOB_DISABLE;
      if (r < 15) return JOB_WRITE_ALL;
      if (r < 18) return JOB_ERASE_ALL;
      if (r < 43) return JOB_WRITE;
      if (r < 78) return JOB_READ;
      if (r < 88) return JOB_ERASE;
      return JOB_NOISE;
   endfunction

   // Result side: stall patterns of random length, one long hold-off on request
   initial begin
      int seg, kind;
      wait (!reset);
      forever begin
         if (hold_now && !hold_done) begin
            hold_done = 1'b1;
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end else begin
            seg = $urandom_range(10, 60);
            kind = $urandom_range(0, 3);
            repeat (seg) begin
               @(negedge clock);
               case (kind)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= 1'($urandom_range(0, 1));
                  2: rsp_stall <= ($urandom_range(0, 3) != 0);
                  default: rsp_stall <= ~rsp_stall;
               endcase
            end
         end
      end
   end

   // Stimulus and verdict
   initial begin
      int      idx;
      job_type job;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed: decode extremes, ignored addresses, select and start together
      put_item(OP_PIN_READ, PIN_ADDR, 8'h00);
      put_item(OP_PIN_READ, 16'hA08F, 8'hFF);
      put_item(OP_PIN_READ, 16'hFFFF, 8'hFF);
      put_item(OP_PIN_READ, 16'h0000, 8'h00);
      put_item(OP_PIN_READ, 16'h5F7F, 8'h00);
      put_item(OP_PIN_READ, 16'hFF8F, 8'h00);
      put_item(OP_PIN_WRITE, 16'h0000, 8'hFF);
      put_item(OP_PIN_WRITE, 16'hFFFF, 8'hFF);
      put_item(OP_PIN_WRITE, 16'hA081, 8'hC2);
      put_item(OP_PIN_WRITE, PIN_ADDR, 8'h00);
      put_item(OP_PIN_WRITE, PIN_ADDR, 8'hFF);
      put_item(OP_PIN_WRITE, PIN_ADDR, 8'h80);
      put_item(OP_PIN_READ, PIN_ADDR, 8'hFF);
      put_item(OP_PIN_WRITE, PIN_ADDR, 8'h3D);
      put_item(OP_PIN_WRITE, PIN_ADDR, 8'h40);
      put_item(OP_PIN_WRITE, PIN_ADDR, 8'h00);
      put_item(OP_PIN_READ, 16'hA080, 8'h00);

      // Command sequences with random content, some cut short, some noise
      idx = 0;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= ITEM_TARGET / 2) hold_now = 1'b1;
         job = choose_job(idx);
         run_job(job, idx > 12 && $urandom_range(0, 9) == 0);
         job_count[job]++;
         idx++;
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain, then let a fill sweep run out
      while (outstanding != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("tb: %0d pin transactions, %0d read results compared, %0d cycles",
               items_sent, checked_count, cycle_count);
      $display("tb: reads %0d, writes %0d, erases %0d, fills %0d, %s %0d, noise %0d",
               job_count[JOB_READ], job_count[JOB_WRITE], job_count[JOB_ERASE],
               job_count[JOB_WRITE_ALL] + job_count[JOB_ERASE_ALL], "enable/disable",
               job_count[JOB_ENABLE] + job_count[JOB_DISABLE], job_count[JOB_NOISE]);
      if (error_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
